/* design/sat_pkg.sv */
package sat_pkg;

	// input command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam int unsigned POS_BITS   = 6;
	localparam int unsigned COUNT_BITS = 7;
	localparam int unsigned KEY_W      = 32;

	// controller -> datapath
	typedef struct packed {
		logic       start;      // latch command and key, open search window
		logic       bs_rd;      // read entry at window midpoint
		logic       bs_upd;     // narrow window from read data
		logic       j_init_up;  // shift pointer := count
		logic       j_init_dn;  // shift pointer := insert/match point
		logic       sh_rd_up;   // read entry j-1
		logic       sh_wr_up;   // write entry j, step down
		logic       sh_rd_dn;   // read entry j+1
		logic       sh_wr_dn;   // write entry j, step up
		logic       ins_wr;     // write new key, count up
		logic       cnt_dec;    // count down
		logic       resp;       // load result register
		logic [1:0] resp_status;
	} sat_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       full;
		logic       lo_lt_hi;
		logic       eq;
		logic       j_gt_lo;
		logic       j1_lt_cnt;
		logic       out_free;
	} sat_stat_t;

endpackage

/* design/sat_ctrl.sv */
module sat_ctrl import sat_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  sat_stat_t stat,
	output sat_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_BS    = 4'd2;
	localparam logic [3:0] S_BSCMP = 4'd3;
	localparam logic [3:0] S_UP    = 4'd4;
	localparam logic [3:0] S_UPWR  = 4'd5;
	localparam logic [3:0] S_DN    = 4'd6;
	localparam logic [3:0] S_DNWR  = 4'd7;
	localparam logic [3:0] S_RESP  = 4'd8;

	logic [3:0] state_q, state_d;
	logic [1:0] res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.resp_status = res_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.cmd)
					CMD_INSERT: begin
						if (stat.full) begin
							res_d   = ST_FULL;
							state_d = S_RESP;
						end else begin
							state_d = S_BS;
						end
					end
					CMD_SEARCH, CMD_REMOVE: state_d = S_BS;
					default: begin
						res_d   = ST_NOT_FOUND;
						state_d = S_RESP;
					end
				endcase
			end
			S_BS: begin
				if (stat.lo_lt_hi) begin
					cmd.bs_rd = 1'b1;
					state_d   = S_BSCMP;
				end else if (stat.cmd == CMD_INSERT) begin
					cmd.j_init_up = 1'b1;
					state_d       = S_UP;
				end else if (stat.eq && stat.cmd == CMD_REMOVE) begin
					cmd.j_init_dn = 1'b1;
					state_d       = S_DN;
				end else begin
					res_d   = stat.eq ? ST_OK : ST_NOT_FOUND;
					state_d = S_RESP;
				end
			end
			S_BSCMP: begin
				cmd.bs_upd = 1'b1;
				state_d    = S_BS;
			end
			S_UP: begin
				if (stat.j_gt_lo) begin
					cmd.sh_rd_up = 1'b1;
					state_d      = S_UPWR;
				end else begin
					cmd.ins_wr = 1'b1;
					res_d      = ST_OK;
					state_d    = S_RESP;
				end
			end
			S_UPWR: begin
				cmd.sh_wr_up = 1'b1;
				state_d      = S_UP;
			end
			S_DN: begin
				if (stat.j1_lt_cnt) begin
					cmd.sh_rd_dn = 1'b1;
					state_d      = S_DNWR;
				end else begin
					cmd.cnt_dec = 1'b1;
					res_d       = ST_OK;
					state_d     = S_RESP;
				end
			end
			S_DNWR: begin
				cmd.sh_wr_dn = 1'b1;
				state_d      = S_DN;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.resp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* design/sat_dp.sv */
module sat_dp import sat_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned KEY_BITS    = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             cmd_in,
	input  logic [KEY_W-1:0]       key_in,
	input  sat_cmd_t               cmd,
	output sat_stat_t              stat,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [1:0]             status,
	output logic [POS_BITS-1:0]    position,
	output logic [COUNT_BITS-1:0]  entry_count
);

	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	logic signed [KEY_BITS-1:0] mem [TABLE_DEPTH];
	logic signed [KEY_BITS-1:0] key_ext;
	logic signed [KEY_BITS-1:0] key_q;
	logic signed [KEY_BITS-1:0] rd_q;
	logic [1:0]                 cmd_q;
	logic [CW-1:0]              cnt_q, lo_q, hi_q, j_q;
	logic                       eq_q;
	logic [CW:0]                win_sum, jp1;
	logic [CW-1:0]              mid, jm1;
	logic                       rd_en, wr_en;
	logic [IW-1:0]              rd_addr, wr_addr;
	logic signed [KEY_BITS-1:0] wr_data;
	logic [CW+POS_BITS-1:0]     pos_wide;
	logic [CW+COUNT_BITS-1:0]   cnt_wide;

	function automatic logic [CW-1:0] jp1_mid(input logic [CW-1:0] m);
		jp1_mid = m + 1'b1;
	endfunction

	// low KEY_BITS of the key, sign extended when the table is wider
	generate
		if (KEY_BITS > KEY_W) begin : g_ext
			assign key_ext = {{(KEY_BITS - KEY_W){key_in[KEY_W-1]}}, key_in};
		end else begin : g_trunc
			assign key_ext = key_in[KEY_BITS-1:0];
		end
	endgenerate

	assign win_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = win_sum[CW:1];
	assign jm1     = j_q - 1'b1;
	assign jp1     = {1'b0, j_q} + 1'b1;

	assign rd_en = cmd.bs_rd | cmd.sh_rd_up | cmd.sh_rd_dn;
	always_comb begin
		rd_addr = mid[IW-1:0];
		if (cmd.sh_rd_up)
			rd_addr = jm1[IW-1:0];
		else if (cmd.sh_rd_dn)
			rd_addr = jp1[IW-1:0];
	end

	assign wr_en   = cmd.sh_wr_up | cmd.sh_wr_dn | cmd.ins_wr;
	assign wr_addr = cmd.ins_wr ? lo_q[IW-1:0] : j_q[IW-1:0];
	assign wr_data = cmd.ins_wr ? key_q : rd_q;

	// key store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= key_ext;
			cmd_q <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			lo_q  <= '0;
			hi_q  <= '0;
			j_q   <= '0;
			eq_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				lo_q <= '0;
				hi_q <= cnt_q;
				eq_q <= 1'b0;
			end else if (cmd.bs_upd) begin
				if (rd_q < key_q) begin
					lo_q <= jp1_mid(mid);
				end else begin
					hi_q <= mid;
					eq_q <= (rd_q == key_q);
				end
			end
			if (cmd.j_init_up)
				j_q <= cnt_q;
			else if (cmd.j_init_dn)
				j_q <= lo_q;
			else if (cmd.sh_wr_up)
				j_q <= jm1;
			else if (cmd.sh_wr_dn)
				j_q <= jp1[CW-1:0];
			if (cmd.ins_wr)
				cnt_q <= cnt_q + 1'b1;
			else if (cmd.cnt_dec)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// result register
	assign pos_wide = {{POS_BITS{1'b0}}, lo_q};
	assign cnt_wide = {{COUNT_BITS{1'b0}}, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.resp) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			status      <= cmd.resp_status;
			position    <= (cmd.resp_status == ST_OK) ? pos_wide[POS_BITS-1:0] : '0;
			entry_count <= cnt_wide[COUNT_BITS-1:0];
		end
	end

	assign stat.cmd       = cmd_q;
	assign stat.full      = (cnt_q == CW'(TABLE_DEPTH));
	assign stat.lo_lt_hi  = (lo_q < hi_q);
	assign stat.eq        = eq_q;
	assign stat.j_gt_lo   = (j_q > lo_q);
	assign stat.j1_lt_cnt = (jp1 < {1'b0, cnt_q});
	assign stat.out_free  = !m_tvalid || m_tready;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_win_order: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi_q)
		else $error("search window inverted");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |-> (cnt_q < CW'(TABLE_DEPTH)))
		else $error("insert write into full table");

	a_resp_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp |-> stat.out_free)
		else $error("result loaded over pending transfer");

	a_rm_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.j_init_dn |-> (eq_q && cnt_q != '0))
		else $error("remove shift without a match");

endmodule

/* design/sorted_array_table_unit.sv */
// Sorted key table: holds up to TABLE_DEPTH signed keys in ascending order.
// Input channel s_*: one command per transfer; s_tuser carries the command
// (insert, search, remove), s_tdata the 32-bit key. Output channel m_*: one
// result per command; m_tuser carries the status (ok, not found, full),
// m_tdata the position and the entry count after the command.
// Steps per command, from the input transfer to m_tvalid rising,
// with n = entries stored before it:
//   dispatch, binary search with a read and a compare step per probe (at most
//   ceil(log2(n+1)) probes, none on an empty table), a step to close the
//   search, then a read and a write per entry moved (insert moves the entries
//   at and above the insert point, remove those above the match), the insert
//   write or count update (insert and hit remove only), and the load of the
//   result register. Full inserts and unused codes go from dispatch to the load.
// The key memory, read through a register, sets the pace: each moved entry
// takes a read and then a write. One command is in work at a time;
// s_tready is high only while the controller is idle, so the next transfer
// comes at the earliest in the cycle after the result load.
// The result sits in an output register, so a new command is taken while a
// result still waits; a stalled m_tready holds the result and the next
// command waits before its own result load until the register frees up.
// Reset empties the table at once (count to zero); the memory needs no clear.
module sorted_array_table_unit import sat_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned KEY_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] key
	input  logic [1:0]  s_tuser,   // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [5:0] position, [12:6] entry_count, [15:13] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	sat_cmd_t                cmd;
	sat_stat_t               stat;
	logic [POS_BITS-1:0]     position;
	logic [COUNT_BITS-1:0]   entry_count;

	// sequencer: search, shift and response steps
	sat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// key memory, search window, shift pointer, count and result register
	sat_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_in      (s_tuser),
		.key_in      (s_tdata),
		.cmd         (cmd),
		.stat        (stat),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.status      (m_tuser),
		.position    (position),
		.entry_count (entry_count)
	);

	assign m_tdata = {3'b000, entry_count, position};

endmodule

/* test/sat_result_checker.sv */
`timescale 1ns / 1ps

module sat_result_checker import sat_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] position;
		logic [6:0] count;
	} reply_t;

	// shadow copy of the sorted keys
	logic signed [KEY_W-1:0] key_store [DEPTH];
	int unsigned             stored;

	reply_t replies_due [$];
	reply_t got_reply;
	reply_t want_reply;
	int     err_count = 0;
	logic   bad_field;

	initial begin
		mismatches  = 0;
		outstanding = 0;
		stored      = 0;
	end

	// lowest index whose key is not below the given key
	function automatic int unsigned first_not_below(logic signed [KEY_W-1:0] key);
		int unsigned i;
		i = 0;
		while (i < stored && key_store[i] < key)
			i++;
		return i;
	endfunction

	function automatic reply_t apply_command(logic [1:0] cmd, logic signed [KEY_W-1:0] key);
		reply_t      r;
		int unsigned p;
		r.status   = ST_NOT_FOUND;
		r.position = '0;
		case (cmd)
			CMD_INSERT: begin
				if (stored >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					p = first_not_below(key);
					for (int unsigned j = stored; j > p; j--)
						key_store[j] = key_store[j - 1];
					key_store[p] = key;
					stored++;
					r.status   = ST_OK;
					r.position = p[5:0];
				end
			end
			CMD_SEARCH, CMD_REMOVE: begin
				p = first_not_below(key);
				if (p < stored && key_store[p] == key) begin
					r.status   = ST_OK;
					r.position = p[5:0];
					if (cmd == CMD_REMOVE) begin
						for (int unsigned j = p; j + 1 < stored; j++)
							key_store[j] = key_store[j + 1];
						stored--;
					end
				end
			end
			default: ;  // unused code leaves the keys alone
		endcase
		r.count = stored[6:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored = 0;
			replies_due.delete();
		end else begin
			// results first: a command taken at this edge cannot answer at it
			if (m_tvalid && m_tready) begin
				got_reply.status   = m_tuser;
				got_reply.position = m_tdata[5:0];
				got_reply.count    = m_tdata[12:6];
				if (replies_due.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: unexpected result status %0d position %0d count %0d",
							$realtime, got_reply.status, got_reply.position, got_reply.count);
				end else begin
					want_reply = replies_due.pop_front();
					bad_field  = (got_reply.status != want_reply.status) ||
						(got_reply.position != want_reply.position) ||
						(got_reply.count != want_reply.count) || (m_tdata[15:13] != 3'b000);
					if (bad_field) begin
						err_count++;
						if (err_count <= 10)
							$display({"%0t: result differs: status %0d/%0d position %0d/%0d ",
								"count %0d/%0d pad %0d (expected/actual)"}, $realtime,
								want_reply.status, got_reply.status, want_reply.position,
								got_reply.position, want_reply.count, got_reply.count,
								m_tdata[15:13]);
					end
				end
			end
			if (s_tvalid && s_tready)
				replies_due.push_back(apply_command(s_tuser, $signed(s_tdata)));
		end
		mismatches  <= err_count;
		outstanding <= replies_due.size();
	end

endmodule

/* test/tb_sorted_array_table_unit.sv */
`timescale 1ns / 1ps

module tb_sorted_array_table_unit;
	import sat_pkg::*;

	// code 3 has no name in the package; the block must ignore it
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// cycles with no transfer on either channel before the run is abandoned;
	// the slowest command (63 entries moved) stays well within this limit
	localparam int IDLE_LIMIT = 4000;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

	// all inputs known from time zero
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;    // [31:0] key
	logic [1:0]  s_tuser  = '0;    // [1:0] command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // [5:0] position, [12:6] entry_count, [15:13] zero
	logic [1:0]  m_tuser;          // [1:0] status

	int mismatches;
	int outstanding;

	// set during one phase so that both sides run back to back
	bit no_idle     = 1'b0;
	int stall_left  = 0;
	int idle_cycles = 0;

	// keys that collide often: extremes, their neighbors, alternating bits
	logic [31:0] key_pool [12] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001,
		32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001, 32'h7fff_fffe, 32'd100,
		32'hffff_ff9c, 32'h5555_5555, 32'haaaa_aaaa, 32'd42};

	// recently inserted keys, so that searches and removes hit random keys too
	logic [31:0] recent_keys [$];

	phase_kind_t phase_plan [6] = '{PH_FILL, PH_DRAIN, PH_MIXED, PH_FILL, PH_MIXED, PH_DRAIN};

	initial forever #5 clk = ~clk;

	sorted_array_table_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sat_result_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Result side: after each transfer draw a random stall. The
	// count runs whether or not a result is waiting, so low tready lands on
	// every phase of the block's work, including the result register load.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left = 0;
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				stall_left = no_idle ? 0 : $urandom_range(0, 7);
			else if (stall_left > 0)
				stall_left--;
			m_tready <= (stall_left == 0);
		end
	end

	// Watchdog: any transfer restarts the count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// One command transfer. tvalid only drops when a gap is drawn, so a
	// back-to-back command never sees valid lowered and raised in one step.
	task automatic send_item(logic [1:0] cmd, logic [31:0] key);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= key;
		do @(posedge clk); while (!s_tready);
	endtask

	// Hold off the sender until every result is back. outstanding is a
	// registered copy of the checker's count, which only makes the wait longer.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// command mix per phase; about one in fifty is the unused code
	function automatic logic [1:0] pick_command(phase_kind_t kind);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return CMD_UNUSED;
		case (kind)
			PH_FILL: begin
				if (r < 85) return CMD_INSERT;
				if (r < 95) return CMD_SEARCH;
				return CMD_REMOVE;
			end
			PH_DRAIN: begin
				if (r < 17) return CMD_INSERT;
				if (r < 32) return CMD_SEARCH;
				return CMD_REMOVE;
			end
			default: begin
				if (r < 42) return CMD_INSERT;
				if (r < 70) return CMD_SEARCH;
				return CMD_REMOVE;
			end
		endcase
	endfunction

	// Inserts mix pool keys with full-range random ones (every key bit
	// toggles); searches and removes mostly aim at keys likely present.
	function automatic logic [31:0] pick_key(logic [1:0] cmd);
		int unsigned r;
		logic [31:0] k;
		r = $urandom_range(0, 99);
		if (cmd == CMD_INSERT) begin
			k = (r < 40) ? key_pool[$urandom_range(0, 11)] : $urandom();
			recent_keys.push_back(k);
			if (recent_keys.size() > 64)
				recent_keys.delete(0);
		end else if (r < 50 && recent_keys.size() != 0) begin
			k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		end else if (r < 80) begin
			k = key_pool[$urandom_range(0, 11)];
		end else begin
			k = $urandom();
		end
		return k;
	endfunction

	initial begin
		logic [1:0] cmd;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty table: nothing to find or remove, unused code ignored
		send_item(CMD_SEARCH, 32'h0000_0000);
		send_item(CMD_REMOVE, 32'h0000_0000);
		send_item(CMD_UNUSED, 32'h0000_0000);
		// extremes and their neighbors, out of order
		send_item(CMD_INSERT, 32'h0000_0000);
		send_item(CMD_INSERT, 32'h7fff_ffff);
		send_item(CMD_INSERT, 32'h8000_0000);
		send_item(CMD_INSERT, 32'hffff_ffff);
		send_item(CMD_INSERT, 32'h0000_0001);
		// duplicates go ahead of the equal keys already stored
		send_item(CMD_INSERT, 32'h0000_0000);
		send_item(CMD_INSERT, 32'h7fff_ffff);
		send_item(CMD_SEARCH, 32'h8000_0000);
		send_item(CMD_SEARCH, 32'h7fff_ffff);
		send_item(CMD_SEARCH, 32'h0000_0000);
		send_item(CMD_SEARCH, 32'h5555_5555);
		send_item(CMD_SEARCH, 32'haaaa_aaaa);
		// unused code with a key that is present: still ignored
		send_item(CMD_UNUSED, 32'hffff_ffff);
		// remove one copy of a duplicate, then the other, then miss
		send_item(CMD_REMOVE, 32'h0000_0000);
		send_item(CMD_SEARCH, 32'h0000_0000);
		send_item(CMD_REMOVE, 32'h0000_0000);
		send_item(CMD_SEARCH, 32'h0000_0000);
		send_item(CMD_REMOVE, 32'h0000_0000);
		// remove at both ends
		send_item(CMD_REMOVE, 32'h8000_0000);
		send_item(CMD_REMOVE, 32'h7fff_ffff);
		wait_drained();

		// Random phases. Fill phases run the table into full-insert rejects,
		// drain phases empty it again; the sender waits for every result at
		// each phase boundary.
		for (int ph = 0; ph < 6; ph++) begin
			no_idle <= (ph == 2);
			for (int n = 0; n < 100; n++) begin
				cmd = pick_command(phase_plan[ph]);
				send_item(cmd, pick_key(cmd));
			end
			wait_drained();
		end

		// tail: catch any stray result after the last one expected
		repeat (200) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
